[design/tprs_pkg.sv]
// Shared widths, codes and handshake structs for the timer prescaler/reload solver.
package tprs_pkg;

  localparam int CLK_W  = 29;  // clock_hz register
  localparam int AMT_W  = 32;  // amount field
  localparam int MULB_W = 24;  // amount width once the range check has passed
  localparam int CNT_W  = 33;  // tick count, at most about 5.4e9
  localparam int DVS_W  = 20;  // divisor width, holds 1000000
  localparam int P_W    = 17;  // divisor search, ceil(count/65535) <= 81940
  localparam int HALF_W = 16;  // prescale and reload
  localparam int ST_W   = 3;
  localparam int UNIT_W = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CLK_W-1:0]  CLOCK_RESET = CLK_W'(72000000);
  localparam logic [DVS_W-1:0]  DIV_MS      = DVS_W'(1000);
  localparam logic [DVS_W-1:0]  DIV_US      = DVS_W'(1000000);
  localparam logic [DVS_W-1:0]  DIV_MAX16   = DVS_W'(16'hFFFF);
  localparam logic [P_W-1:0]    P_MAX       = P_W'(16'hFFFF);
  localparam logic [AMT_W-1:0]  LIMIT_S     = AMT_W'(10);
  localparam logic [AMT_W-1:0]  LIMIT_MS    = AMT_W'(10000);
  localparam logic [AMT_W-1:0]  LIMIT_US    = AMT_W'(10000000);

  localparam logic [UNIT_W-1:0] UNIT_S   = 2'd0;
  localparam logic [UNIT_W-1:0] UNIT_MS  = 2'd1;
  localparam logic [UNIT_W-1:0] UNIT_US  = 2'd2;
  localparam logic [UNIT_W-1:0] UNIT_BAD = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd1;
  localparam logic [ST_W-1:0] ST_NODIV = 3'd2;
  localparam logic [ST_W-1:0] ST_UNIT  = 3'd3;
  localparam logic [ST_W-1:0] ST_ZERO  = 3'd4;

  localparam logic ADDR_CLOCK = 1'b0;  // word index of clock_hz

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

[design/tprs_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
module tprs_div
  import tprs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(CNT_W + 1);

  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             active;
  logic             done;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem, quo[CNT_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= CW'(CNT_W);
      end else if (active) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (active) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[CNT_W-2:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

[design/tprs_mul.sv]
// Bit-serial shift-and-add multiplier, multiplier bits taken MSB first.
module tprs_mul
  import tprs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CLK_W-1:0]  a,
  input  logic [MULB_W-1:0] b,
  output logic              done,
  output logic [CNT_W-1:0]  product
);

  localparam int CW = $clog2(MULB_W + 1);

  logic [CLK_W-1:0]  mcand;
  logic [MULB_W-1:0] mplier;
  logic [CW-1:0]     cnt;
  logic              active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CW'(MULB_W);
      end else if (active) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // product never exceeds CNT_W bits, so partial sums do not either
  always_ff @(posedge clk) begin
    if (start) begin
      product <= '0;
      mcand   <= a;
      mplier  <= b;
    end else if (active) begin
      product <= {product[CNT_W-2:0], 1'b0}
                 + (mplier[MULB_W-1] ? CNT_W'(mcand) : CNT_W'(0));
      mplier  <= {mplier[MULB_W-2:0], 1'b0};
    end
  end

endmodule

[design/timer_prescaler_reload_solver.sv]
// Top level: sequencer, clock register and result register of the prescaler/reload solver.
//
// Usage: raise start with unit and amount; the beat is taken on an edge where busy is low.
// busy stays high until the answer is formed. The answer appears on status, prescale and
// reload for exactly one cycle, marked by done; the receiver cannot hold it off, and busy
// is already low in that cycle, so a new beat may be taken there.
// The user writes clock_hz through the APB-style port (byte address 0) only while the
// block is idle; the block itself does not enforce it. Steps: a bad unit or out-of-range
// amount is answered straight from the check. Otherwise the ms/us base division runs
// (skipped for seconds), then the serial multiply, the first-divisor estimate and one
// division per trial divisor. Every divide runs on one 33-step bit-serial divider, which
// sets the rate; one item is in flight at a time.
// Reset: sequencer idle, no result pending, clock_hz back to 72 MHz.
// The count is formed exactly (33 bits); the search starts at ceil(count/65535), so the
// first divisor that leaves no remainder gives a quotient that fits 16 bits.
module timer_prescaler_reload_solver
  import tprs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [UNIT_W-1:0] unit,
  input  logic [AMT_W-1:0]  amount,
  output logic              done,
  output logic [ST_W-1:0]   status,
  output logic [HALF_W-1:0] prescale,
  output logic [HALF_W-1:0] reload,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_BASE  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_CEIL  = 3'd4;
  localparam logic [2:0] S_TRY   = 3'd5;

  logic [2:0]        state, state_next;
  logic [CLK_W-1:0]  clock_hz;
  logic [UNIT_W-1:0] unit_r;
  logic [AMT_W-1:0]  amount_r;
  logic [CNT_W-1:0]  count, count_next;
  logic [P_W-1:0]    p, p_next;
  logic              done_next;
  logic [ST_W-1:0]   status_next;
  logic [HALF_W-1:0] prescale_next, reload_next;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              mul_start;
  logic [CLK_W-1:0]  mul_a;
  logic              mul_done;
  logic [CNT_W-1:0]  mul_product;

  logic [AMT_W-1:0]  limit;
  logic [P_W-1:0]    p_first;

  // config port: zero wait states, one register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_CLOCK) ? DATA_W'(clock_hz) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_CLOCK) begin
      clock_hz <= pwdata[CLK_W-1:0];
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    case (unit_r)
      UNIT_S:  limit = LIMIT_S;
      UNIT_MS: limit = LIMIT_MS;
      default: limit = LIMIT_US;
    endcase
  end

  // ceil(count/65535) from the floor quotient and remainder
  assign p_first = div_rsp.quotient[P_W-1:0] + P_W'(div_rsp.remainder != '0);

  tprs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tprs_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (amount_r[MULB_W-1:0]),
    .done    (mul_done),
    .product (mul_product)
  );

  always_comb begin
    state_next    = state;
    count_next    = count;
    p_next        = p;
    done_next     = 1'b0;
    status_next   = status;
    prescale_next = prescale;
    reload_next   = reload;
    div_req       = '0;
    mul_start     = 1'b0;
    mul_a         = clock_hz;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (unit_r == UNIT_BAD) begin
          done_next = 1'b1; status_next = ST_UNIT;
          prescale_next = '0; reload_next = '0; state_next = S_IDLE;
        end else if (amount_r > limit) begin
          done_next = 1'b1; status_next = ST_RANGE;
          prescale_next = '0; reload_next = '0; state_next = S_IDLE;
        end else if (unit_r == UNIT_S) begin
          mul_start  = 1'b1;
          state_next = S_MUL;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = CNT_W'(clock_hz);
          div_req.divisor  = (unit_r == UNIT_MS) ? DIV_MS : DIV_US;
          state_next       = S_BASE;
        end
      end
      S_BASE: begin
        if (div_rsp.done) begin
          mul_start  = 1'b1;
          mul_a      = div_rsp.quotient[CLK_W-1:0];
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          count_next = mul_product;
          if (mul_product == '0) begin
            done_next = 1'b1; status_next = ST_ZERO;
            prescale_next = '0; reload_next = '0; state_next = S_IDLE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = mul_product;
            div_req.divisor  = DIV_MAX16;
            state_next       = S_CEIL;
          end
        end
      end
      S_CEIL: begin
        if (div_rsp.done) begin
          if (p_first > P_MAX) begin
            done_next = 1'b1; status_next = ST_NODIV;
            prescale_next = '0; reload_next = '0; state_next = S_IDLE;
          end else begin
            p_next           = p_first;
            div_req.start    = 1'b1;
            div_req.dividend = count;
            div_req.divisor  = DVS_W'(p_first);
            state_next       = S_TRY;
          end
        end
      end
      S_TRY: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            done_next     = 1'b1;
            status_next   = ST_OK;
            prescale_next = p[HALF_W-1:0] - HALF_W'(1);
            reload_next   = div_rsp.quotient[HALF_W-1:0] - HALF_W'(1);
            state_next    = S_IDLE;
          end else if (p == P_MAX) begin
            done_next = 1'b1; status_next = ST_NODIV;
            prescale_next = '0; reload_next = '0; state_next = S_IDLE;
          end else begin
            p_next           = p + P_W'(1);
            div_req.start    = 1'b1;
            div_req.dividend = count;
            div_req.divisor  = DVS_W'(p + P_W'(1));
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      unit_r   <= unit;
      amount_r <= amount;
    end
    count    <= count_next;
    p        <= p_next;
    status   <= status_next;
    prescale <= prescale_next;
    reload   <= reload_next;
  end

`ifndef NO_ASSERTIONS
  a_zero_unless_ok: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> prescale == '0 && reload == '0)
    else $error("non-ok result carries nonzero fields");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not start the sequencer");

  a_p_range: assert property (@(posedge clk) disable iff (rst)
    state == S_TRY |-> p != '0 && p <= P_MAX)
    else $error("trial divisor out of range");
`endif

endmodule
